### hdl/assert_macros.svh
// Assertion macros included by the controller top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property, sampled on the rising clock, off while reset is held.
`define ASSERT_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Boolean condition that must never be seen at a clock edge.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  `ASSERT_AT(label, clk, rst_n, !(cond))

`endif

### hdl/slpc_pkg.sv
// Types and constants of the status LED priority controller.
`timescale 1ns / 1ps

package slpc_pkg;

  // Field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned ARGB_W  = 32;
  localparam int unsigned FLASH_W = 2;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned GPER_W  = 26;
  localparam int unsigned RPER_W  = 7;

  // Duty divider: on*255 / (on+off), quotient always below 256
  localparam int unsigned QUOT_W     = LEVEL_W;
  localparam int unsigned DIVIDEND_W = TIME_W + QUOT_W;
  localparam int unsigned DIVISOR_W  = TIME_W + 1;
  localparam int unsigned DIV_CNT_W  = $clog2(QUOT_W + 1);

  typedef enum logic [OP_W-1:0] {
    OP_BACKLIGHT = 2'd0,
    OP_NOTIFY    = 2'd1,
    OP_ATTENTION = 2'd2,
    OP_BATTERY   = 2'd3
  } op_e;

  typedef enum logic [FLASH_W-1:0] {
    FLASH_NONE  = 2'd0,
    FLASH_TIMED = 2'd1,
    FLASH_HW    = 2'd2
  } flash_e;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 8'd255;
  localparam logic [LEVEL_W-1:0] DUTY_MIN   = 8'd16;
  localparam logic [LEVEL_W-1:0] BATT_LOW   = 8'd15;
  localparam logic [LEVEL_W-1:0] BATT_MID   = 8'd99;
  localparam logic [RPER_W-1:0]  LED_PERIOD = 7'd100;
  localparam logic [GPER_W-1:0]  US_PER_MS  = 26'd1000;

  // Luma weights, sum scaled by 256
  localparam logic [15:0] LUMA_R = 16'd77;
  localparam logic [15:0] LUMA_G = 16'd150;
  localparam logic [15:0] LUMA_B = 16'd29;

endpackage

### hdl/slpc_req_if.sv
// Request channel: one light request per word.
`timescale 1ns / 1ps

interface slpc_req_if;
  import slpc_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [ARGB_W-1:0]  argb;
  logic [FLASH_W-1:0] flash_kind;
  logic [TIME_W-1:0]  on_time_ms;
  logic [TIME_W-1:0]  off_time_ms;

  modport source (
    output valid, op, argb, flash_kind, on_time_ms, off_time_ms,
    input  ready
  );

  modport sink (
    input  valid, op, argb, flash_kind, on_time_ms, off_time_ms,
    output ready
  );
endinterface

### hdl/slpc_rsp_if.sv
// Result channel: snapshot of the LED and backlight registers per word.
`timescale 1ns / 1ps

interface slpc_rsp_if;
  import slpc_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] backlight_level;
  logic [LEVEL_W-1:0] green_level;
  logic [GPER_W-1:0]  green_period_us;
  logic [LEVEL_W-1:0] red_level;
  logic [RPER_W-1:0]  red_period_us;

  modport source (
    output valid, backlight_level, green_level, green_period_us, red_level, red_period_us,
    input  ready
  );

  modport sink (
    input  valid, backlight_level, green_level, green_period_us, red_level, red_period_us,
    output ready
  );
endinterface

### hdl/slpc_div.sv
// Bit-serial restoring divider for the blink duty cycle.
`timescale 1ns / 1ps

module slpc_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [slpc_pkg::DIVIDEND_W-1:0] dividend_i,
  input  logic [slpc_pkg::DIVISOR_W-1:0]  divisor_i,
  output logic                            done_o,
  output logic [slpc_pkg::QUOT_W-1:0]     quotient_o
);
  import slpc_pkg::*;

  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [QUOT_W-1:0]    quo_q, quo_d;
  logic [DIVISOR_W-1:0] den_q;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  // Dividend high part is below the divisor, so only QUOT_W steps are needed.
  // The low dividend bits shift out of quo_q while quotient bits shift in.
  assign trial = {rem_q, quo_q[QUOT_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = DIVISOR_W'(dividend_i[DIVIDEND_W-1:QUOT_W]);
      quo_d = dividend_i[QUOT_W-1:0];
      cnt_d = DIV_CNT_W'(QUOT_W);
    end else if (cnt_q != '0) begin
      rem_d  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_d  = {quo_q[QUOT_W-2:0], ge};
      cnt_d  = cnt_q - DIV_CNT_W'(1);
      done_d = (cnt_q == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### hdl/status_led_priority_controller_unit.sv
// Status LED priority controller: top level.
//
// Takes light requests on req_i (op, argb, flash_kind, on/off times) and
// returns one word on rsp_o per request: the backlight level and the green
// and red LED level/period registers as they stand after the request.
// Notification and attention requests are kept in slots; the LED follows the
// lit attention slot, then the lit notification slot, then the request.
// Backlight, battery and steady LED requests pass the select and commit states
// into the rsp_o register; a blinking LED request also passes the divide state,
// where the 8-step radix-2 duty divider gives one quotient bit per cycle.
// One request is in work at a time; req_i.ready is high in the idle state,
// also while an earlier word still waits in the rsp_o register.
// If rsp_o stalls, the finished request holds before commit and the
// registers only change when the output register is free.
// Reset clears the slots and all LED/backlight registers to zero and leaves
// rsp_o empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module status_led_priority_controller_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  slpc_req_if.sink   req_i,
  slpc_rsp_if.source rsp_o
);
  import slpc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEL    = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic req_fire;
  logic commit;

  // Request word
  logic [OP_W-1:0]    op_q;
  logic [ARGB_W-1:0]  argb_q;
  logic [FLASH_W-1:0] flash_q;
  logic [TIME_W-1:0]  on_q;
  logic [TIME_W-1:0]  off_q;

  // Slots
  logic [ARGB_W-1:0]  att_argb_q, not_argb_q;
  logic [FLASH_W-1:0] att_flash_q, not_flash_q;
  logic [TIME_W-1:0]  att_on_q, att_off_q, not_on_q, not_off_q;

  // Architectural registers
  logic [LEVEL_W-1:0] backlight_q, backlight_d;
  logic [LEVEL_W-1:0] green_level_q, green_level_d;
  logic [GPER_W-1:0]  green_period_q, green_period_d;
  logic [LEVEL_W-1:0] red_level_q, red_level_d;
  logic [RPER_W-1:0]  red_period_q, red_period_d;

  // Output word
  logic               rsp_valid_q;
  logic [LEVEL_W-1:0] rsp_bl_q, rsp_gl_q, rsp_rl_q;
  logic [GPER_W-1:0]  rsp_gp_q;
  logic [RPER_W-1:0]  rsp_rp_q;

  // Source selection
  logic [ARGB_W-1:0]  src_argb;
  logic [FLASH_W-1:0] src_flash;
  logic [TIME_W-1:0]  src_on, src_off;
  logic               src_lit;
  logic               blink_d, blink_q;
  logic [LEVEL_W-1:0] steady_d, steady_q;
  logic [GPER_W-1:0]  gper_calc_d, gper_calc_q;
  logic [15:0]        luma;
  logic [LEVEL_W-1:0] bl_calc_q;
  logic               led_op;

  // Divider
  logic                  div_start;
  logic                  div_done;
  logic [QUOT_W-1:0]     div_quot;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic [LEVEL_W-1:0]    duty;
  logic                  batt_lit;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid & req_i.ready;
  assign commit      = (state_q == ST_COMMIT) & (~rsp_valid_q | rsp_o.ready);
  assign led_op      = (op_q == OP_NOTIFY) || (op_q == OP_ATTENTION);

  // ---------------------------------------------------------------- capture
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q    <= req_i.op;
      argb_q  <= req_i.argb;
      flash_q <= req_i.flash_kind;
      on_q    <= req_i.on_time_ms;
      off_q   <= req_i.off_time_ms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      att_argb_q  <= '0;
      att_flash_q <= '0;
      att_on_q    <= '0;
      att_off_q   <= '0;
      not_argb_q  <= '0;
      not_flash_q <= '0;
      not_on_q    <= '0;
      not_off_q   <= '0;
    end else if (req_fire) begin
      if (req_i.op == OP_ATTENTION) begin
        att_argb_q  <= req_i.argb;
        att_flash_q <= req_i.flash_kind;
        att_on_q    <= req_i.on_time_ms;
        att_off_q   <= req_i.off_time_ms;
      end
      if (req_i.op == OP_NOTIFY) begin
        not_argb_q  <= req_i.argb;
        not_flash_q <= req_i.flash_kind;
        not_on_q    <= req_i.on_time_ms;
        not_off_q   <= req_i.off_time_ms;
      end
    end
  end

  // ----------------------------------------------------------- select stage
  always_comb begin
    if (att_argb_q[23:0] != '0) begin
      src_argb  = att_argb_q;
      src_flash = att_flash_q;
      src_on    = att_on_q;
      src_off   = att_off_q;
    end else if (not_argb_q[23:0] != '0) begin
      src_argb  = not_argb_q;
      src_flash = not_flash_q;
      src_on    = not_on_q;
      src_off   = not_off_q;
    end else begin
      src_argb  = argb_q;
      src_flash = flash_q;
      src_on    = on_q;
      src_off   = off_q;
    end
    src_lit = (src_argb[23:0] != '0);
    blink_d = ((src_flash == FLASH_TIMED) || (src_flash == FLASH_HW)) &&
              (src_on != '0) && (src_off != '0);
    if (!src_lit) begin
      steady_d = '0;
    end else if (src_argb[31:24] == '0) begin
      steady_d = LEVEL_FULL;
    end else begin
      steady_d = src_argb[31:24];
    end
    gper_calc_d = blink_d ? ({{(GPER_W-TIME_W){1'b0}}, src_off} * US_PER_MS)
                          : GPER_W'(LED_PERIOD);
  end

  // on*255 as on*256 - on
  assign div_dividend = {src_on, {QUOT_W{1'b0}}} - {{QUOT_W{1'b0}}, src_on};
  assign div_divisor  = {1'b0, src_on} + {1'b0, src_off};
  assign div_start    = (state_q == ST_SEL) && led_op && blink_d;

  assign luma = ({8'd0, argb_q[23:16]} * LUMA_R) + ({8'd0, argb_q[15:8]} * LUMA_G) +
                ({8'd0, argb_q[7:0]} * LUMA_B);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SEL) begin
      blink_q     <= blink_d;
      steady_q    <= steady_d;
      gper_calc_q <= gper_calc_d;
      bl_calc_q   <= luma[15:8];
    end
  end

  slpc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign duty = ((div_quot != '0) && (div_quot < DUTY_MIN)) ? DUTY_MIN : div_quot;

  // ---------------------------------------------------------- commit values
  assign batt_lit = (argb_q[23:0] != '0);

  always_comb begin
    backlight_d    = backlight_q;
    green_level_d  = green_level_q;
    green_period_d = green_period_q;
    red_level_d    = red_level_q;
    red_period_d   = red_period_q;
    case (op_q)
      OP_BACKLIGHT: begin
        backlight_d = bl_calc_q;
      end
      OP_NOTIFY, OP_ATTENTION: begin
        red_level_d    = '0;
        green_level_d  = blink_q ? duty : steady_q;
        green_period_d = gper_calc_q;
      end
      OP_BATTERY: begin
        green_level_d = '0;
        red_level_d   = '0;
        if (batt_lit) begin
          // alpha up to 15 shows red, up to 99 yellow, above that green
          if (argb_q[31:24] <= BATT_LOW) begin
            red_level_d  = LEVEL_FULL;
            red_period_d = LED_PERIOD;
          end else if (argb_q[31:24] <= BATT_MID) begin
            green_level_d  = LEVEL_FULL;
            green_period_d = GPER_W'(LED_PERIOD);
            red_level_d    = LEVEL_FULL;
            red_period_d   = LED_PERIOD;
          end else begin
            green_level_d  = LEVEL_FULL;
            green_period_d = GPER_W'(LED_PERIOD);
          end
        end
      end
      default: begin
        backlight_d = backlight_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backlight_q    <= '0;
      green_level_q  <= '0;
      green_period_q <= '0;
      red_level_q    <= '0;
      red_period_q   <= '0;
    end else if (commit) begin
      backlight_q    <= backlight_d;
      green_level_q  <= green_level_d;
      green_period_q <= green_period_d;
      red_level_q    <= red_level_d;
      red_period_q   <= red_period_d;
    end
  end

  // ------------------------------------------------------------ output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (commit) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      rsp_bl_q <= backlight_d;
      rsp_gl_q <= green_level_d;
      rsp_gp_q <= green_period_d;
      rsp_rl_q <= red_level_d;
      rsp_rp_q <= red_period_d;
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.backlight_level = rsp_bl_q;
  assign rsp_o.green_level     = rsp_gl_q;
  assign rsp_o.green_period_us = rsp_gp_q;
  assign rsp_o.red_level       = rsp_rl_q;
  assign rsp_o.red_period_us   = rsp_rp_q;

  // ------------------------------------------------------------------- FSM
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = ST_SEL;
        end
      end
      ST_SEL: begin
        state_d = div_start ? ST_DIV : ST_COMMIT;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ------------------------------------------------------------- assertions
  `ASSERT_NEVER(a_div_done_outside_div, clk_i, rst_ni, div_done && (state_q != ST_DIV))
  `ASSERT_AT(a_rsp_from_commit, clk_i, rst_ni, $rose(rsp_valid_q) |-> $past(commit))
  `ASSERT_AT(a_led_clears_red, clk_i, rst_ni, (commit && led_op) |=> (red_level_q == '0))

endmodule

### test/tb_status_led_priority_controller_unit.sv
// Self-checking bench for the status LED priority controller: directed table, then random requests.
`timescale 1ns / 1ps

module tb_status_led_priority_controller_unit;
  import slpc_pkg::*;

  localparam int unsigned        RANDOM_REQUESTS = 1550;
  localparam int unsigned        IDLE_PCT        = 19;
  localparam int unsigned        DRAIN_CYCLES    = 20;
  localparam logic [FLASH_W-1:0] FLASH_RESERVED  = 2'd3;
  localparam logic [LEVEL_W-1:0] BATT_CAP        = 8'd100;

  typedef struct packed {
    op_e                op;
    logic [ARGB_W-1:0]  argb;
    logic [FLASH_W-1:0] flash_kind;
    logic [TIME_W-1:0]  on_ms;
    logic [TIME_W-1:0]  off_ms;
  } light_req_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] backlight;
    logic [LEVEL_W-1:0] green;
    logic [GPER_W-1:0]  green_period;
    logic [LEVEL_W-1:0] red;
    logic [RPER_W-1:0]  red_period;
  } led_snapshot_t;

  typedef struct packed {
    light_req_t    req;
    logic          known;
    led_snapshot_t snap;
  } directed_row_t;

  localparam led_snapshot_t NO_SNAP = '0;

  // Rows with known set carry a hand-worked register snapshot.
  localparam int unsigned DIRECTED_ROWS = 25;
  localparam directed_row_t DIRECTED[DIRECTED_ROWS] = '{
    '{'{OP_BACKLIGHT, 32'h0000_0000, FLASH_NONE, 16'd0, 16'd0}, 1'b1,
      '{8'd0, 8'd0, 26'd0, 8'd0, 7'd0}},
    '{'{OP_BACKLIGHT, 32'h00ff_ffff, FLASH_NONE, 16'd0, 16'd0}, 1'b1,
      '{8'd255, 8'd0, 26'd0, 8'd0, 7'd0}},
    '{'{OP_BATTERY, 32'hff00_0001, FLASH_NONE, 16'd0, 16'd0}, 1'b1,
      '{8'd255, 8'd255, 26'd100, 8'd0, 7'd0}},
    '{'{OP_BATTERY, 32'h0f00_0001, FLASH_NONE, 16'd0, 16'd0}, 1'b1,
      '{8'd255, 8'd0, 26'd100, 8'd255, 7'd100}},
    '{'{OP_BATTERY, 32'h10ff_ffff, FLASH_TIMED, 16'hffff, 16'hffff}, 1'b1,
      '{8'd255, 8'd255, 26'd100, 8'd255, 7'd100}},
    '{'{OP_BATTERY, 32'h6380_0000, FLASH_HW, 16'd1, 16'd1}, 1'b0, NO_SNAP},
    '{'{OP_BATTERY, 32'h6400_0000, FLASH_NONE, 16'd0, 16'd0}, 1'b1,
      '{8'd255, 8'd0, 26'd100, 8'd0, 7'd100}},
    '{'{OP_BATTERY, 32'h0000_0000, FLASH_NONE, 16'd0, 16'd0}, 1'b0, NO_SNAP},
    '{'{OP_BACKLIGHT, 32'hffff_0000, FLASH_RESERVED, 16'hffff, 16'hffff}, 1'b0, NO_SNAP},
    '{'{OP_NOTIFY, 32'h0000_0000, FLASH_NONE, 16'd0, 16'd0}, 1'b0, NO_SNAP},
    '{'{OP_NOTIFY, 32'h00ff_0000, FLASH_TIMED, 16'hffff, 16'hffff}, 1'b1,
      '{8'd76, 8'd127, 26'd65535000, 8'd0, 7'd100}},
    '{'{OP_NOTIFY, 32'h00ff_0000, FLASH_TIMED, 16'd1, 16'hffff}, 1'b0, NO_SNAP},
    '{'{OP_NOTIFY, 32'h00ff_0000, FLASH_HW, 16'd1000, 16'hffff}, 1'b0, NO_SNAP},
    '{'{OP_NOTIFY, 32'h0000_ff00, FLASH_TIMED, 16'hffff, 16'd1}, 1'b0, NO_SNAP},
    '{'{OP_NOTIFY, 32'h0000_00ff, FLASH_HW, 16'd5, 16'd0}, 1'b0, NO_SNAP},
    '{'{OP_NOTIFY, 32'h80ff_00ff, FLASH_RESERVED, 16'd100, 16'd100}, 1'b0, NO_SNAP},
    '{'{OP_ATTENTION, 32'hff00_0000, FLASH_TIMED, 16'd100, 16'd100}, 1'b0, NO_SNAP},
    '{'{OP_ATTENTION, 32'h4000_0100, FLASH_HW, 16'd300, 16'd700}, 1'b0, NO_SNAP},
    '{'{OP_NOTIFY, 32'h0000_0000, FLASH_NONE, 16'd0, 16'd0}, 1'b0, NO_SNAP},
    '{'{OP_BATTERY, 32'h3200_0001, FLASH_NONE, 16'd0, 16'd0}, 1'b0, NO_SNAP},
    '{'{OP_ATTENTION, 32'h0000_0000, FLASH_NONE, 16'd0, 16'd0}, 1'b0, NO_SNAP},
    '{'{OP_NOTIFY, 32'h01ff_ffff, FLASH_NONE, 16'hffff, 16'hffff}, 1'b0, NO_SNAP},
    '{'{OP_BACKLIGHT, 32'h0000_00ff, FLASH_NONE, 16'd0, 16'd0}, 1'b0, NO_SNAP},
    '{'{OP_BACKLIGHT, 32'h0000_ff00, FLASH_NONE, 16'd0, 16'd0}, 1'b0, NO_SNAP},
    '{'{OP_ATTENTION, 32'hffff_ffff, FLASH_TIMED, 16'd0, 16'd50}, 1'b0, NO_SNAP}
  };

  logic clk_i;
  logic rst_ni;

  slpc_req_if req_bus ();
  slpc_rsp_if rsp_bus ();

  status_led_priority_controller_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // Shadow of the block state
  light_req_t    attention_slot;
  light_req_t    notice_slot;
  led_snapshot_t led_regs;

  led_snapshot_t pending_snapshots[$];
  int unsigned   fault_count;
  logic          steady_phase;

  function automatic logic is_lit(logic [ARGB_W-1:0] argb);
    return argb[23:0] != '0;
  endfunction

  function automatic void show_source(light_req_t src);
    logic [31:0] on_ms;
    logic [31:0] off_ms;
    logic [31:0] duty;
    on_ms  = 32'(src.on_ms);
    off_ms = 32'(src.off_ms);
    if (src.flash_kind != FLASH_TIMED && src.flash_kind != FLASH_HW) begin
      on_ms  = '0;
      off_ms = '0;
    end
    led_regs.red = '0;
    if (on_ms != 0 && off_ms != 0) begin
      duty = (on_ms * 32'(LEVEL_FULL)) / (on_ms + off_ms);
      if (duty > 0 && duty < 32'(DUTY_MIN)) duty = 32'(DUTY_MIN);
      led_regs.green        = duty[LEVEL_W-1:0];
      led_regs.green_period = GPER_W'(off_ms * 32'(US_PER_MS));
    end else begin
      led_regs.green = '0;
      if (is_lit(src.argb))
        led_regs.green = (src.argb[31:24] == '0) ? LEVEL_FULL : src.argb[31:24];
      led_regs.green_period = GPER_W'(LED_PERIOD);
    end
  endfunction

  function automatic led_snapshot_t predict_led_registers(light_req_t r);
    logic [31:0]        luma;
    logic [LEVEL_W-1:0] charge;
    case (r.op)
      OP_BACKLIGHT: begin
        luma = 32'(LUMA_R) * 32'(r.argb[23:16]) + 32'(LUMA_G) * 32'(r.argb[15:8])
             + 32'(LUMA_B) * 32'(r.argb[7:0]);
        led_regs.backlight = luma[15:8];
      end
      OP_NOTIFY, OP_ATTENTION: begin
        if (r.op == OP_NOTIFY) notice_slot = r;
        else attention_slot = r;
        if (is_lit(attention_slot.argb)) show_source(attention_slot);
        else if (is_lit(notice_slot.argb)) show_source(notice_slot);
        else show_source(r);
      end
      default: begin
        charge = (r.argb[31:24] > BATT_CAP) ? BATT_CAP : r.argb[31:24];
        led_regs.green = '0;
        led_regs.red   = '0;
        if (is_lit(r.argb)) begin
          if (charge <= BATT_LOW) begin
            led_regs.red        = LEVEL_FULL;
            led_regs.red_period = LED_PERIOD;
          end else if (charge <= BATT_MID) begin
            led_regs.green        = LEVEL_FULL;
            led_regs.green_period = GPER_W'(LED_PERIOD);
            led_regs.red          = LEVEL_FULL;
            led_regs.red_period   = LED_PERIOD;
          end else begin
            led_regs.green        = LEVEL_FULL;
            led_regs.green_period = GPER_W'(LED_PERIOD);
          end
        end
      end
    endcase
    return led_regs;
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return TIME_W'($urandom_range(1, 50));
      default: return TIME_W'($urandom);
    endcase
  endfunction

  function automatic light_req_t random_request();
    light_req_t r;
    r.op         = op_e'($urandom_range(3));
    r.argb       = $urandom;
    r.flash_kind = FLASH_W'($urandom_range(3));
    r.on_ms      = pick_time();
    r.off_ms     = pick_time();
    // Unlit colors clear the slot's claim on the LED
    if ($urandom_range(4) == 0) r.argb[23:0] = '0;
    // Charge levels around the battery thresholds
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(6))
        0:       r.argb[31:24] = 8'd0;
        1:       r.argb[31:24] = BATT_LOW;
        2:       r.argb[31:24] = BATT_LOW + 8'd1;
        3:       r.argb[31:24] = BATT_MID;
        4:       r.argb[31:24] = BATT_CAP;
        5:       r.argb[31:24] = BATT_CAP + 8'd1;
        default: r.argb[31:24] = LEVEL_FULL;
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fault_count++;
  endtask

  task automatic check_snapshot(led_snapshot_t got);
    led_snapshot_t want;
    if (pending_snapshots.size() == 0) begin
      report_mismatch("result word with none outstanding");
    end else begin
      want = pending_snapshots.pop_front();
      if (got.backlight !== want.backlight)
        report_mismatch($sformatf("backlight_level %0d, want %0d", got.backlight, want.backlight));
      if (got.green !== want.green)
        report_mismatch($sformatf("green_level %0d, want %0d", got.green, want.green));
      if (got.green_period !== want.green_period)
        report_mismatch($sformatf("green_period_us %0d, want %0d",
                                  got.green_period, want.green_period));
      if (got.red !== want.red)
        report_mismatch($sformatf("red_level %0d, want %0d", got.red, want.red));
      if (got.red_period !== want.red_period)
        report_mismatch($sformatf("red_period_us %0d, want %0d",
                                  got.red_period, want.red_period));
    end
  endtask

  // Present one request word; returns once it has been accepted.
  task automatic send_request(light_req_t r);
    while (!steady_phase && $urandom_range(99) < IDLE_PCT) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid       <= 1'b1;
    req_bus.op          <= r.op;
    req_bus.argb        <= r.argb;
    req_bus.flash_kind  <= r.flash_kind;
    req_bus.on_time_ms  <= r.on_ms;
    req_bus.off_time_ms <= r.off_ms;
    do @(posedge clk_i); while (!req_bus.ready);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result side: random back-pressure, check on every accepted word
  initial begin
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_bus.valid && rsp_bus.ready)
        check_snapshot('{rsp_bus.backlight_level, rsp_bus.green_level,
                         rsp_bus.green_period_us, rsp_bus.red_level, rsp_bus.red_period_us});
      rsp_bus.ready <= steady_phase || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    light_req_t    r;
    led_snapshot_t snap;
    fault_count    = 0;
    steady_phase   = 1'b0;
    attention_slot = '0;
    notice_slot    = '0;
    led_regs       = '0;
    rst_ni              <= 1'b0;
    req_bus.valid       <= 1'b0;
    req_bus.op          <= '0;
    req_bus.argb        <= '0;
    req_bus.flash_kind  <= '0;
    req_bus.on_time_ms  <= '0;
    req_bus.off_time_ms <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_request(DIRECTED[i].req);
      snap = predict_led_registers(DIRECTED[i].req);
      pending_snapshots.push_back(DIRECTED[i].known ? DIRECTED[i].snap : snap);
    end

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      // One long stretch with both sides streaming
      steady_phase = (i >= 600 && i < 900);
      r = random_request();
      send_request(r);
      pending_snapshots.push_back(predict_led_registers(r));
    end
    steady_phase = 1'b0;
    req_bus.valid <= 1'b0;

    while (pending_snapshots.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
